>>> hdl/tea_block_encrypt_top_macros.svh
// assertion macros shared by the tea block encryption design
`ifndef TEA_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define TEA_BLOCK_ENCRYPT_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define TBE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbe assertion failed");

// antecedent implies consequent in the next cycle
`define TBE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbe assertion failed");

`else

`define TBE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TBE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hdl/tbe_pkg.sv
`default_nettype none

package tbe_pkg;

   // round constant added to the running sum once per round
   localparam logic [31:0] DELTA = 32'h9E3779B9;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD0_INDEX = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD1_INDEX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD2_INDEX = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] KEY_WORD3_INDEX = 3'd3;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } key_type;

   typedef struct packed {
      logic [31:0] left;
      logic [31:0] right;
   } block_type;

   // running sum seen in round r (counting from zero), modulo 2^32
   function automatic logic [31:0] round_sum(input int unsigned r);
      logic [63:0] product;
      product = 64'(r + 1) * 64'(DELTA);
      return product[31:0];
   endfunction

   // one feistel mixing function
   function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] sum,
                                       input logic [31:0] ka, input logic [31:0] kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

endpackage

`default_nettype wire

>>> hdl/tbe_key_regs.sv
`default_nettype none

module tbe_key_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [tbe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [31:0]                          csr_write_data,
   output tbe_pkg::key_type                          keys
);

   tbe_pkg::key_type key_ff;
   tbe_pkg::key_type key_in;

   // decode the register index, unknown indexes leave the key alone
   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         case (csr_index)
            tbe_pkg::KEY_WORD0_INDEX: key_in.word0 = csr_write_data;
            tbe_pkg::KEY_WORD1_INDEX: key_in.word1 = csr_write_data;
            tbe_pkg::KEY_WORD2_INDEX: key_in.word2 = csr_write_data;
            tbe_pkg::KEY_WORD3_INDEX: key_in.word3 = csr_write_data;
            default: key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign keys = key_ff;

endmodule

`default_nettype wire

>>> hdl/tbe_stage.sv
`default_nettype none

module tbe_stage #(
   parameter int unsigned STAGE = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               prev_valid,
   input  wire tbe_pkg::block_type prev_data,
   input  wire tbe_pkg::key_type   keys,
   output logic                    stage_valid,
   output tbe_pkg::block_type      stage_data
);

   // even stages update the left half, odd stages the right half
   localparam logic [31:0] SUM      = tbe_pkg::round_sum(STAGE / 2);
   localparam bit          IS_RIGHT = (STAGE % 2) == 1;

   logic               valid_ff;
   logic               valid_in;
   tbe_pkg::block_type data_ff;
   tbe_pkg::block_type data_in;

   // one half-round
   always_comb begin
      data_in = prev_data;
      if (IS_RIGHT) begin
         data_in.right = prev_data.right
                       + tbe_pkg::mix(prev_data.left, SUM, keys.word2, keys.word3);
      end else begin
         data_in.left = prev_data.left
                      + tbe_pkg::mix(prev_data.right, SUM, keys.word0, keys.word1);
      end
      valid_in = prev_valid;
   end

   // stage register, a full stage holds while the next stage is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

`default_nettype wire

>>> hdl/tea_block_encrypt_top.sv
`default_nettype none

// TEA block encryption under a 128-bit key held in four write-only registers
// (csr_index 0 to 3 select key_word0 to key_word3, other indexes are ignored,
// all reset to zero). The datapath is a pipeline of 2*ROUNDS register stages,
// one Feistel half-round in each, and a new block can be taken in every cycle
// while the result side does not stall. Empty stages close up while the result
// side stalls, so the input keeps taking transactions until every stage holds
// a block. The last stage is the result register. Change the key only while no
// transaction is in flight.
`include "tea_block_encrypt_top_macros.svh"

module tea_block_encrypt_top #(
   parameter int unsigned ROUNDS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [31:0]                         req_block_left,
   input  wire logic [31:0]                         req_block_right,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [31:0]                              rsp_cipher_left,
   output logic [31:0]                              rsp_cipher_right,
   input  wire logic                                csr_write_enable,
   input  wire logic [tbe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                         csr_write_data
);

   localparam int unsigned NSTAGE = 2 * ROUNDS;

   tbe_pkg::key_type   keys;
   tbe_pkg::block_type req_data;
   logic               stage_valid [NSTAGE];
   tbe_pkg::block_type stage_data  [NSTAGE];
   logic               stage_ready [NSTAGE+1];

   // key registers
   tbe_key_regs u_key_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .keys             (keys)
   );

   assign req_data.left  = req_block_left;
   assign req_data.right = req_block_right;

   // a stage moves when it is empty or its successor moves
   assign stage_ready[NSTAGE] = !rsp_stall;

   for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
      assign stage_ready[i] = !stage_valid[i] || stage_ready[i+1];

      if (i == 0) begin : g_first
         tbe_stage #(.STAGE(i)) u_stage (
            .clock       (clock),
            .reset       (reset),
            .advance     (stage_ready[i]),
            .prev_valid  (req_valid),
            .prev_data   (req_data),
            .keys        (keys),
            .stage_valid (stage_valid[i]),
            .stage_data  (stage_data[i])
         );
      end else begin : g_rest
         tbe_stage #(.STAGE(i)) u_stage (
            .clock       (clock),
            .reset       (reset),
            .advance     (stage_ready[i]),
            .prev_valid  (stage_valid[i-1]),
            .prev_data   (stage_data[i-1]),
            .keys        (keys),
            .stage_valid (stage_valid[i]),
            .stage_data  (stage_data[i])
         );
      end
   end

   // result side is the last stage register
   assign req_stall        = !stage_ready[0];
   assign rsp_valid        = stage_valid[NSTAGE-1];
   assign rsp_cipher_left  = stage_data[NSTAGE-1].left;
   assign rsp_cipher_right = stage_data[NSTAGE-1].right;

   // checks
   `TBE_ASSERT_SAME(a_empty_tail_accepts, clock, reset, !rsp_valid, !req_stall)
   `TBE_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, stage_valid[0])
   `TBE_ASSERT_NEXT(a_stalled_head_holds, clock, reset,
                    stage_valid[0] && !stage_ready[0], stage_valid[0])

endmodule

`default_nettype wire
